@@ rtl/tli_pkg.sv @@
// Shared constants, field layout and control structs of the table interpolator.
// No dependencies; every other file in rtl/ except tli_ram imports this package.
`default_nettype none

package tli_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned IDX_OUT_W  = 6;
  localparam int unsigned FRAC_OUT_W = 17;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned KIND_W     = 1;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  // Reset value of the entry count register
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  // Input word layout, lowest bits first
  localparam int unsigned IN_SLOT_LSB   = 0;
  localparam int unsigned IN_RADIUS_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_PITCH_LSB  = IN_RADIUS_LSB + VAL_W;
  localparam int unsigned IN_CHORD_LSB  = IN_PITCH_LSB + VAL_W;
  localparam int unsigned IN_QUERY_LSB  = IN_CHORD_LSB + VAL_W;
  localparam int unsigned IN_USED_W     = IN_QUERY_LSB + VAL_W;
  localparam int unsigned IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest bits first
  localparam int unsigned OUT_PITCH_LSB = 0;
  localparam int unsigned OUT_CHORD_LSB = OUT_PITCH_LSB + VAL_W;
  localparam int unsigned OUT_LOWER_LSB = OUT_CHORD_LSB + VAL_W;
  localparam int unsigned OUT_UPPER_LSB = OUT_LOWER_LSB + IDX_OUT_W;
  localparam int unsigned OUT_FRAC_LSB  = OUT_UPPER_LSB + IDX_OUT_W;
  localparam int unsigned OUT_USED_W    = OUT_FRAC_LSB + FRAC_OUT_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

  // Range status codes
  localparam logic [STATUS_W-1:0] RANGE_INTERIOR = 2'd0;
  localparam logic [STATUS_W-1:0] RANGE_BELOW    = 2'd1;
  localparam logic [STATUS_W-1:0] RANGE_ABOVE    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                wr_en;
    logic                load_query;
    logic                scan_shift;
    logic                set_bracket;
    logic [STATUS_W-1:0] range_status;
    logic                div_step;
    logic                pc_sel_hi;
    logic                cap_lo;
    logic                cap_diff;
    logic                cap_prod;
    logic                load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic radius_ge;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/tli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tli_dp.sv @@
// Datapath of the table interpolator: table RAMs, divider, multipliers, result register.
// Depends on tli_pkg and tli_ram; driven by tli_ctrl through cmd_t.
`default_nettype none

module tli_dp #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned FRAC_BITS   = tli_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tli_pkg::cmd_t                       cmd_i,
  output tli_pkg::stat_t                           stat_o,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      scan_addr_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      lo_idx_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      hi_idx_i,
  input  wire logic [tli_pkg::SLOT_W-1:0]          slot_i,
  input  wire logic [tli_pkg::VAL_W-1:0]           radius_i,
  input  wire logic [tli_pkg::VAL_W-1:0]           pitch_i,
  input  wire logic [tli_pkg::VAL_W-1:0]           chord_i,
  input  wire logic [tli_pkg::VAL_W-1:0]           query_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [tli_pkg::VAL_W-1:0]           pitch_o,
  output logic      [tli_pkg::VAL_W-1:0]           chord_o,
  output logic      [tli_pkg::IDX_OUT_W-1:0]       lower_o,
  output logic      [tli_pkg::IDX_OUT_W-1:0]       upper_o,
  output logic      [tli_pkg::FRAC_OUT_W-1:0]      frac_o,
  output logic      [tli_pkg::STATUS_W-1:0]        status_o
);

  import tli_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned REM_W  = VAL_W + 2;
  localparam int unsigned QUOT_W = FRAC_BITS + 1;
  localparam int unsigned PROD_W = QUOT_W + 1 + DIFF_W;

  // Table write
  logic             slot_ok;
  logic [IDX_W-1:0] waddr;
  assign slot_ok = (32'(slot_i) < 32'(TABLE_DEPTH));
  assign waddr   = IDX_W'(slot_i);

  logic [VAL_W-1:0]   rad_rdata;
  logic [2*VAL_W-1:0] pc_rdata;
  logic [IDX_W-1:0]   pc_raddr;

  logic [IDX_W-1:0] i1_q, i2_q;

  assign pc_raddr = cmd_i.pc_sel_hi ? i2_q : i1_q;

  tli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_radius_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && slot_ok),
    .waddr_i (waddr),
    .wdata_i (radius_i),
    .raddr_i (scan_addr_i),
    .rdata_o (rad_rdata)
  );

  tli_ram #(.WIDTH(2 * VAL_W), .DEPTH(TABLE_DEPTH)) u_pc_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && slot_ok),
    .waddr_i (waddr),
    .wdata_i ({chord_i, pitch_i}),
    .raddr_i (pc_raddr),
    .rdata_o (pc_rdata)
  );

  // Scan and bracket registers
  logic [VAL_W-1:0]    q_q, r_prev_q;
  logic [STATUS_W-1:0] status_q;
  logic [REM_W-1:0]    rem_q;
  logic [DIFF_W-1:0]   den_q;
  logic [QUOT_W-1:0]   quot_q;

  logic [DIFF_W-1:0] num_d, den_d;
  assign num_d = {q_q[VAL_W-1], q_q} - {r_prev_q[VAL_W-1], r_prev_q};
  assign den_d = {rad_rdata[VAL_W-1], rad_rdata} - {r_prev_q[VAL_W-1], r_prev_q};

  // One quotient bit per step
  logic             div_ge;
  logic [REM_W-1:0] div_sub, div_rem;
  assign div_ge  = (rem_q >= REM_W'(den_q));
  assign div_sub = rem_q - REM_W'(den_q);
  assign div_rem = div_ge ? div_sub : rem_q;

  assign stat_o.radius_ge = ($signed(rad_rdata) >= $signed(q_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      q_q <= query_i;
    end
    if (cmd_i.scan_shift) begin
      r_prev_q <= rad_rdata;
    end
    if (cmd_i.set_bracket) begin
      i1_q     <= lo_idx_i;
      i2_q     <= hi_idx_i;
      status_q <= cmd_i.range_status;
      rem_q    <= REM_W'(num_d);
      den_q    <= den_d;
      quot_q   <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[QUOT_W-2:0], div_ge};
      rem_q  <= {div_rem[REM_W-2:0], 1'b0};
    end
  end

  // Interpolation
  logic [VAL_W-1:0]         lo_p_q, lo_c_q;
  logic signed [DIFF_W-1:0] diff_p_q, diff_c_q;
  logic signed [PROD_W-1:0] prod_p_q, prod_c_q;
  logic [VAL_W-1:0]         hi_p, hi_c;

  assign hi_p = pc_rdata[VAL_W-1:0];
  assign hi_c = pc_rdata[2*VAL_W-1:VAL_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lo) begin
      lo_p_q <= pc_rdata[VAL_W-1:0];
      lo_c_q <= pc_rdata[2*VAL_W-1:VAL_W];
    end
    if (cmd_i.cap_diff) begin
      diff_p_q <= $signed({hi_p[VAL_W-1], hi_p}) - $signed({lo_p_q[VAL_W-1], lo_p_q});
      diff_c_q <= $signed({hi_c[VAL_W-1], hi_c}) - $signed({lo_c_q[VAL_W-1], lo_c_q});
    end
    if (cmd_i.cap_prod) begin
      prod_p_q <= $signed({1'b0, quot_q}) * diff_p_q;
      prod_c_q <= $signed({1'b0, quot_q}) * diff_c_q;
    end
  end

  // Arithmetic shift is the floor of the scaled product
  logic signed [PROD_W-1:0] shift_p, shift_c;
  assign shift_p = prod_p_q >>> FRAC_BITS;
  assign shift_c = prod_c_q >>> FRAC_BITS;

  // Result register
  logic                  out_valid_q;
  logic [VAL_W-1:0]      pitch_q, chord_q;
  logic [IDX_OUT_W-1:0]  lower_q, upper_q;
  logic [FRAC_OUT_W-1:0] frac_q;
  logic [STATUS_W-1:0]   ostat_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pitch_q <= lo_p_q + shift_p[VAL_W-1:0];
      chord_q <= lo_c_q + shift_c[VAL_W-1:0];
      lower_q <= IDX_OUT_W'(i1_q);
      upper_q <= IDX_OUT_W'(i2_q);
      frac_q  <= FRAC_OUT_W'(quot_q);
      ostat_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pitch_o     = pitch_q;
  assign chord_o     = chord_q;
  assign lower_o     = lower_q;
  assign upper_o     = upper_q;
  assign frac_o      = frac_q;
  assign status_o    = ostat_q;

endmodule

`default_nettype wire

@@ rtl/tli_ctrl.sv @@
// Controller of the table interpolator: entry count register, scan and divide sequencing.
// Depends on tli_pkg; drives tli_dp through cmd_t.
`default_nettype none

module tli_ctrl #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned FRAC_BITS   = tli_pkg::DEF_FRAC_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic [tli_pkg::KIND_W-1:0]       in_kind_i,
  output logic                                  in_ready_o,
  input  wire logic                             cfg_valid_i,
  input  wire logic [tli_pkg::COUNT_W-1:0]      cfg_wdata_i,
  output logic                                  cfg_ready_o,
  input  wire tli_pkg::stat_t                   stat_i,
  output tli_pkg::cmd_t                         cmd_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   scan_addr_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   lo_idx_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   hi_idx_o
);

  import tli_pkg::*;

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned DIV_CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_RD_LO,
    S_RD_HI,
    S_DIFF,
    S_MUL,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [COUNT_W-1:0]   count_q;
  logic [IDX_W-1:0]     last_q, k_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic             accept, is_query;
  logic [31:0]      count_ext;
  logic [IDX_W-1:0] last_d;

  assign accept      = in_valid_i && in_ready_o;
  assign is_query    = (in_kind_i == KIND_QUERY);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Clamp the programmed count to 1..TABLE_DEPTH
  assign count_ext = 32'(count_q);
  always_comb begin
    if (count_ext == 32'd0) begin
      last_d = '0;
    end else if (count_ext > 32'(TABLE_DEPTH)) begin
      last_d = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_d = IDX_W'(count_ext - 32'd1);
    end
  end

  assign scan_addr_o = (state_q == S_IDLE) ? '0 : (k_q + IDX_W'(1));

  always_comb begin
    cmd_o    = '0;
    lo_idx_o = '0;
    hi_idx_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.wr_en      = accept && !is_query;
        cmd_o.load_query = accept && is_query;
        if (accept && is_query && (last_d == '0)) begin
          cmd_o.set_bracket  = 1'b1;
          cmd_o.range_status = RANGE_ABOVE;
        end
      end
      S_SCAN: begin
        if (stat_i.radius_ge) begin
          cmd_o.set_bracket = 1'b1;
          if (k_q == '0) begin
            cmd_o.range_status = RANGE_BELOW;
          end else begin
            cmd_o.range_status = RANGE_INTERIOR;
            lo_idx_o           = k_q - IDX_W'(1);
            hi_idx_o           = k_q;
          end
        end else if (k_q == last_q) begin
          cmd_o.set_bracket  = 1'b1;
          cmd_o.range_status = RANGE_ABOVE;
          lo_idx_o           = last_q;
          hi_idx_o           = last_q;
        end else begin
          cmd_o.scan_shift = 1'b1;
        end
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_RD_LO: cmd_o.pc_sel_hi = 1'b0;
      S_RD_HI: begin
        cmd_o.pc_sel_hi = 1'b1;
        cmd_o.cap_lo    = 1'b1;
      end
      S_DIFF:  cmd_o.cap_diff = 1'b1;
      S_MUL:   cmd_o.cap_prod = 1'b1;
      S_FIN:   cmd_o.load_out = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= COUNT_RESET;
      last_q    <= '0;
      k_q       <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && is_query) begin
            last_q <= last_d;
            k_q    <= '0;
            state_q <= (last_d == '0) ? S_RD_LO : S_SCAN;
          end
        end
        S_SCAN: begin
          div_cnt_q <= '0;
          if (stat_i.radius_ge) begin
            state_q <= (k_q == '0) ? S_RD_LO : S_DIV;
          end else if (k_q == last_q) begin
            state_q <= S_RD_LO;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(FRAC_BITS)) begin
            state_q <= S_RD_LO;
          end
        end
        S_RD_LO: state_q <= S_RD_HI;
        S_RD_HI: state_q <= S_DIFF;
        S_DIFF:  state_q <= S_MUL;
        S_MUL:   state_q <= S_FIN;
        S_FIN: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A query always leaves idle; a write never does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_query) |=> (state_q != S_IDLE))
    else $error("query accepted but controller stayed idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_query) |=> (state_q == S_IDLE))
    else $error("table write left the idle state");

  // Scan never runs past the last entry in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (k_q <= last_q))
    else $error("scan index beyond last entry");

  // Divider runs exactly FRAC_BITS+1 steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q <= DIV_CNT_W'(FRAC_BITS)))
    else $error("divide step count overrun");

  // A result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (stat_i.out_free && (state_q == S_FIN)))
    else $error("result loaded while output busy");

endmodule

`default_nettype wire

@@ rtl/table_linear_interpolator.sv @@
// Top level of the piecewise-linear table interpolator: stream ports and word packing.
// Depends on tli_pkg, tli_ctrl, tli_dp (which holds the tli_ram instances).
// Timing: a table write is stored at its accept edge; a query result is registered after
//   the radius scan, the divide (interior bracket only), the bracket reads and the difference
//   and product captures; a single entry skips the scan.
// Throughput: one query at a time, set by the one-entry-per-cycle radius scan on the
//   RAM read port and the one-bit-per-cycle divider; writes are accepted back to back while idle.
// Reset: asynchronous, active low; clears control and sets entry count to 1, table undefined.
`default_nettype none

module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned FRAC_BITS   = tli_pkg::DEF_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input words
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // entry_index, entry_radius, entry_pitch, entry_chord, query_radius, zero pad
  input  wire logic [tli_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind
  input  wire logic [tli_pkg::KIND_W-1:0]         s_axis_tuser,
  // Result words
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // pitch_out, chord_out, lower_index, upper_index, fraction, zero pad
  output logic      [tli_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // range_status
  output logic      [tli_pkg::STATUS_W-1:0]       m_axis_tuser,
  // Entry count register
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tli_pkg::COUNT_W-1:0]        cfg_wdata_i
);

  import tli_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] scan_addr, lo_idx, hi_idx;

  logic [VAL_W-1:0]      pitch_out, chord_out;
  logic [IDX_OUT_W-1:0]  lower_out, upper_out;
  logic [FRAC_OUT_W-1:0] frac_out;

  // Sequencing: accept, scan, divide, fetch bracket values, interpolate
  tli_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .scan_addr_o (scan_addr),
    .lo_idx_o    (lo_idx),
    .hi_idx_o    (hi_idx)
  );

  // Unpack the input word straight into the datapath
  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .scan_addr_i (scan_addr),
    .lo_idx_i    (lo_idx),
    .hi_idx_i    (hi_idx),
    .slot_i      (s_axis_tdata[IN_SLOT_LSB +: SLOT_W]),
    .radius_i    (s_axis_tdata[IN_RADIUS_LSB +: VAL_W]),
    .pitch_i     (s_axis_tdata[IN_PITCH_LSB +: VAL_W]),
    .chord_i     (s_axis_tdata[IN_CHORD_LSB +: VAL_W]),
    .query_i     (s_axis_tdata[IN_QUERY_LSB +: VAL_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .pitch_o     (pitch_out),
    .chord_o     (chord_out),
    .lower_o     (lower_out),
    .upper_o     (upper_out),
    .frac_o      (frac_out),
    .status_o    (m_axis_tuser)
  );

  // Pack the result word, pad bits held at zero
  always_comb begin
    m_axis_tdata                                = '0;
    m_axis_tdata[OUT_PITCH_LSB +: VAL_W]        = pitch_out;
    m_axis_tdata[OUT_CHORD_LSB +: VAL_W]        = chord_out;
    m_axis_tdata[OUT_LOWER_LSB +: IDX_OUT_W]    = lower_out;
    m_axis_tdata[OUT_UPPER_LSB +: IDX_OUT_W]    = upper_out;
    m_axis_tdata[OUT_FRAC_LSB +: FRAC_OUT_W]    = frac_out;
  end

endmodule

`default_nettype wire

@@ verif/tli_checker.sv @@
`timescale 1ns / 100ps
// Checker for the table interpolator: watches the input, result and count
// channels, predicts every query result and compares it field by field.
// Depends on tli_pkg for widths, word layout and codes.

module tli_checker
  import tli_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [KIND_W-1:0]      s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [STATUS_W-1:0]    m_axis_tuser,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [COUNT_W-1:0]     cfg_wdata_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o
);

  typedef struct packed {
    logic [VAL_W-1:0]      pitch;
    logic [VAL_W-1:0]      chord;
    logic [IDX_OUT_W-1:0]  lower;
    logic [IDX_OUT_W-1:0]  upper;
    logic [FRAC_OUT_W-1:0] frac;
    logic [STATUS_W-1:0]   status;
  } interp_result_t;

  logic signed [VAL_W-1:0] radius_tbl [DEF_TABLE_DEPTH] = '{default: '0};
  logic signed [VAL_W-1:0] pitch_tbl  [DEF_TABLE_DEPTH] = '{default: '0};
  logic signed [VAL_W-1:0] chord_tbl  [DEF_TABLE_DEPTH] = '{default: '0};
  logic [COUNT_W-1:0]      entry_count = COUNT_RESET;

  interp_result_t interp_expected_q [$];
  int unsigned    mismatches = 0;
  int unsigned    outstanding = 0;

  assign pending_o    = outstanding;
  assign fail_count_o = mismatches;

  // lo + floor(frac * (hi - lo) / 2^FRAC_BITS); the arithmetic shift floors
  function automatic logic [VAL_W-1:0] blend(logic signed [VAL_W-1:0] lo,
                                             logic signed [VAL_W-1:0] hi,
                                             longint unsigned frac);
    longint prod;
    prod = longint'(frac) * (longint'(hi) - longint'(lo));
    return VAL_W'(longint'(lo) + (prod >>> DEF_FRAC_BITS));
  endfunction

  function automatic interp_result_t interpolate(logic signed [VAL_W-1:0] q);
    interp_result_t  res;
    int unsigned     n, lo_i, hi_i;
    longint unsigned num, den, frac;
    // Count of 0 behaves as 1, counts above the depth as the full table
    n = (entry_count == 0) ? 1 :
        ((entry_count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : entry_count);
    frac       = 0;
    lo_i       = 0;
    hi_i       = 0;
    res.status = RANGE_ABOVE;
    if (n > 1) begin
      // First breakpoint whose radius is not below the query
      while (hi_i < n && radius_tbl[hi_i] < q) hi_i++;
      if (hi_i == n) begin
        hi_i = n - 1;
        lo_i = hi_i;
      end else if (hi_i == 0) begin
        res.status = RANGE_BELOW;
      end else begin
        // The entry before the hit is below q, so den is always positive
        lo_i       = hi_i - 1;
        num        = longint'(q) - longint'(radius_tbl[lo_i]);
        den        = longint'(radius_tbl[hi_i]) - longint'(radius_tbl[lo_i]);
        frac       = (num << DEF_FRAC_BITS) / den;
        res.status = RANGE_INTERIOR;
      end
    end
    res.pitch = blend(pitch_tbl[lo_i], pitch_tbl[hi_i], frac);
    res.chord = blend(chord_tbl[lo_i], chord_tbl[hi_i], frac);
    res.lower = IDX_OUT_W'(lo_i);
    res.upper = IDX_OUT_W'(hi_i);
    res.frac  = FRAC_OUT_W'(frac);
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    interp_result_t want;
    logic [SLOT_W-1:0] slot;
    if (rst_ni) begin
      // Results first, so a query taken on the same edge cannot claim this word
      if (m_axis_tvalid && m_axis_tready) begin
        if (interp_expected_q.size() == 0) begin
          $error("result word with no query outstanding: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = interp_expected_q.pop_front();
          check_field("pitch_out", want.pitch, m_axis_tdata[OUT_PITCH_LSB +: VAL_W]);
          check_field("chord_out", want.chord, m_axis_tdata[OUT_CHORD_LSB +: VAL_W]);
          check_field("lower_index", want.lower, m_axis_tdata[OUT_LOWER_LSB +: IDX_OUT_W]);
          check_field("upper_index", want.upper, m_axis_tdata[OUT_UPPER_LSB +: IDX_OUT_W]);
          check_field("fraction", want.frac, m_axis_tdata[OUT_FRAC_LSB +: FRAC_OUT_W]);
          check_field("range_status", want.status, m_axis_tuser);
        end
      end
      if (cfg_valid_i && cfg_ready_o) entry_count = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_WRITE) begin
          slot             = s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
          radius_tbl[slot] = s_axis_tdata[IN_RADIUS_LSB +: VAL_W];
          pitch_tbl[slot]  = s_axis_tdata[IN_PITCH_LSB +: VAL_W];
          chord_tbl[slot]  = s_axis_tdata[IN_CHORD_LSB +: VAL_W];
        end else begin
          interp_expected_q.push_back(interpolate(s_axis_tdata[IN_QUERY_LSB +: VAL_W]));
        end
      end
      outstanding = interp_expected_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Top of the table interpolator testbench: clock, reset, stimulus and verdict.
// Depends on tli_pkg, table_linear_interpolator and tli_checker.

module tb
  import tli_pkg::*;
;

  // Allow for the slowest legal query, the longest sender gap and
  // the longest result stall per word, then leave a wide margin on top.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // Quiet time before a count write and before the verdict
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned TOTAL_WORDS  = 2100;
  localparam longint      VAL_MIN      = -(longint'(1) << (VAL_W - 1));
  localparam longint      VAL_MAX      = (longint'(1) << (VAL_W - 1)) - 1;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = KIND_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [COUNT_W-1:0]     cfg_wdata_i   = COUNT_RESET;

  int unsigned results_pending;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned stall_left  = 0;
  logic        idle_on     = 1'b1;

  // Radii as last written, used only to aim queries at the table
  logic signed [VAL_W-1:0] written_radius [DEF_TABLE_DEPTH] = '{default: '0};

  table_linear_interpolator u_dut (.*);

  tli_checker u_checker (
    .pending_o    (results_pending),
    .fail_count_o (mismatch_count),
    .*
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // Pitch or chord value, biased toward the extremes
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_word(logic [SLOT_W-1:0] slot,
                                                      logic [VAL_W-1:0]  radius,
                                                      logic [VAL_W-1:0]  pitch,
                                                      logic [VAL_W-1:0]  chord,
                                                      logic [VAL_W-1:0]  query);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_SLOT_LSB +: SLOT_W]  = slot;
    word[IN_RADIUS_LSB +: VAL_W] = radius;
    word[IN_PITCH_LSB +: VAL_W]  = pitch;
    word[IN_CHORD_LSB +: VAL_W]  = chord;
    word[IN_QUERY_LSB +: VAL_W]  = query;
    return word;
  endfunction

  // Hold valid across back-to-back words; drop it only ahead of a gap
  task automatic send_word(logic [KIND_W-1:0] kind, logic [IN_TDATA_W-1:0] data);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Query fields of a write word carry noise; the block must ignore them
  task automatic write_entry(logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] radius,
                             logic [VAL_W-1:0] pitch, logic [VAL_W-1:0] chord);
    written_radius[slot] = radius;
    send_word(KIND_WRITE, pack_word(slot, radius, pitch, chord, $urandom));
  endtask

  task automatic send_query(logic [VAL_W-1:0] radius);
    send_word(KIND_QUERY, pack_word(SLOT_W'($urandom), $urandom, $urandom, $urandom, radius));
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Load the first n entries with ascending radii at a random scale;
  // a zero step now and then gives equal neighbors
  task automatic fill_table(int unsigned n);
    longint step_max, r;
    step_max = longint'(1) << $urandom_range(0, 25);
    r        = rand_between(VAL_MIN, VAL_MAX - DEF_TABLE_DEPTH * step_max);
    for (int unsigned i = 0; i < n; i++) begin
      write_entry(SLOT_W'(i), VAL_W'(r), pick_value(), pick_value());
      r += rand_between(0, step_max);
    end
  endtask

  // Aim most queries around the table in use, some at or next to breakpoints
  function automatic logic [VAL_W-1:0] pick_query(int unsigned n);
    int unsigned roll;
    longint      lo, hi, margin;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom;
    if (roll < 30) return written_radius[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
    lo     = written_radius[0];
    hi     = written_radius[n - 1];
    if (lo > hi) begin
      margin = lo;
      lo     = hi;
      hi     = margin;
    end
    margin = (hi - lo) / 8 + 1;
    lo     = (lo - margin < VAL_MIN) ? VAL_MIN : lo - margin;
    hi     = (hi + margin > VAL_MAX) ? VAL_MAX : hi + margin;
    return VAL_W'(rand_between(lo, hi));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return COUNT_W'(1);
    if (roll < 12) return COUNT_W'(0);
    if (roll < 20) return COUNT_W'(DEF_TABLE_DEPTH);
    if (roll < 26) return COUNT_W'($urandom_range(DEF_TABLE_DEPTH + 1, (1 << COUNT_W) - 1));
    if (roll < 40) return COUNT_W'($urandom_range(17, DEF_TABLE_DEPTH - 1));
    return COUNT_W'($urandom_range(2, 16));
  endfunction

  // Result side: random stalls while idling is on, ready held high otherwise
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= idle_on ? pick_gap() : 0;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] count;
    int unsigned        n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single entry at reset count: extremes of value and query
    write_entry(SLOT_W'(0), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    write_entry(SLOT_W'(1), 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    write_entry(SLOT_W'(2), 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);

    // Count of zero behaves as a single entry
    wait_idle();
    write_count(COUNT_W'(0));
    send_query(32'h0000_0005);

    wait_idle();
    write_count(COUNT_W'(3));
    send_query(32'h8000_0000);  // at first radius: clamp below
    send_query(32'hFFFF_FFFF);  // interior, fraction just short of one
    send_query(32'h0000_0000);  // on a breakpoint: full fraction
    send_query(32'h0000_0001);  // interior, fraction truncates to zero
    send_query(32'h7FFF_FFFF);  // on the last radius
    send_query(32'h4000_0000);
    // Pull the last radius in so a query can land above it
    write_entry(SLOT_W'(2), 32'h0000_03E8, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    send_query(32'h0000_01F4);
    send_query(32'h0000_03E9);
    // Unsorted table: scan stops at the first radius not below the query
    write_entry(SLOT_W'(1), 32'h7FFF_FFF0, 32'h1234_5678, 32'hFEDC_BA98);
    send_query(32'h0000_01F4);
    send_query(32'h7FFF_FFF5);

    // Define every entry before any count can reach beyond the first three
    fill_table(DEF_TABLE_DEPTH);

    while (words_sent < TOTAL_WORDS) begin
      wait_idle();
      count = pick_count();
      write_count(count);
      n       = (count == 0) ? 1 : ((count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : count);
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) fill_table(n);
      repeat ($urandom_range(15, 60)) begin
        // Stray writes anywhere in the table, radius unconstrained
        if ($urandom_range(0, 9) == 0)
          write_entry(SLOT_W'($urandom), $urandom, pick_value(), pick_value());
        else
          send_query(pick_query(n));
      end
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_dp.sv
rtl/tli_ctrl.sv
rtl/table_linear_interpolator.sv
verif/tli_checker.sv
verif/tb.sv
